// ===== hdl/fpcc_pkg.sv =====
// Shared types, constants and tables for the fire pixel colour classifier.
package fpcc_pkg;

    localparam int COLOR_BITS = 8;
    localparam int SUM_W      = 10;
    localparam int XY_W       = 28;
    localparam int Z_W        = 21;
    localparam int REM_W      = 11;
    localparam int QUO_W      = 17;
    localparam int HUE_W      = 12;
    localparam int THR_W      = 24;

    localparam logic [4:0]  CORDIC_STEPS  = 5'd16;
    localparam logic [4:0]  ITER_STAGES   = 5'd17;
    localparam logic [16:0] SQRT3_Q16     = 17'd113512;
    localparam logic [12:0] HUE_HALF_TURN = 13'd2880;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MOTION_GATE = 3'd0;
    localparam logic [2:0] REG_RED_THR     = 3'd1;
    localparam logic [2:0] REG_HUE_MAX     = 3'd2;
    localparam logic [2:0] REG_SUM_MIN     = 3'd3;
    localparam logic [2:0] REG_SAT_SLOPE   = 3'd4;

    // Configuration values as seen by the datapath.
    typedef struct packed {
        logic        motion_gate_enable;
        logic [7:0]  red_threshold;
        logic [8:0]  hue_max_degrees;
        logic [9:0]  intensity_sum_min;
        logic [15:0] saturation_slope;
    } fpcc_cfg_t;

    // Contents of one iteration stage: CORDIC vector and divider state.
    typedef struct packed {
        logic                    valid;
        logic                    rgb_ok;
        logic [SUM_W-1:0]        sum;
        logic [THR_W-1:0]        sat_thr;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic [REM_W-1:0]        rem;
        logic [QUO_W-1:0]        quo;
    } fpcc_iter_t;

    // Arctangent of 2^-i in units of 1/4096 degree.
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 21'sd184320;
            5'd1:    v = 21'sd108810;
            5'd2:    v = 21'sd57492;
            5'd3:    v = 21'sd29184;
            5'd4:    v = 21'sd14649;
            5'd5:    v = 21'sd7331;
            5'd6:    v = 21'sd3667;
            5'd7:    v = 21'sd1833;
            5'd8:    v = 21'sd917;
            5'd9:    v = 21'sd458;
            5'd10:   v = 21'sd229;
            5'd11:   v = 21'sd115;
            5'd12:   v = 21'sd57;
            5'd13:   v = 21'sd29;
            5'd14:   v = 21'sd14;
            5'd15:   v = 21'sd7;
            default: v = 21'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/fpcc_front.sv =====
// Front end: colour rule, channel sum and set-up of the CORDIC and divider.
module fpcc_front (
    input  logic [7:0]           blue,
    input  logic [7:0]           green,
    input  logic [7:0]           red,
    input  logic                 motion,
    input  logic                 valid,
    input  fpcc_pkg::fpcc_cfg_t  cfg,
    output fpcc_pkg::fpcc_iter_t init
);

    logic signed [10:0] a_val;
    logic [7:0]         s_val;
    logic [24:0]        y_prod;
    logic [9:0]         sum;
    logic [9:0]         num;

    // Colour differences and the scaled vector for the hue angle.
    always_comb
    begin
        sum    = 10'(red) + 10'(green) + 10'(blue);
        num    = sum - 10'(10'(blue) * 10'd3);
        a_val  = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
                 - $signed({3'b000, blue});
        s_val  = green - blue;
        y_prod = 25'(s_val) * 25'(fpcc_pkg::SQRT3_Q16);

        init.valid   = valid;
        init.rgb_ok  = (red > cfg.red_threshold) && (red >= green) && (green > blue)
                       && (motion || !cfg.motion_gate_enable);
        init.sum     = sum;
        init.sat_thr = 24'(8'hFF - red) * 24'(cfg.saturation_slope);
        init.x       = {a_val[10], a_val, 16'h0000};
        init.y       = $signed({3'b000, y_prod});
        init.z       = '0;
        init.rem     = {1'b0, num};
        init.quo     = '0;
    end

endmodule

// ===== hdl/fpcc_iter_stage.sv =====
// One iteration: a CORDIC vectoring step (only for steps below CORDIC_STEPS) and one restoring divider step.
module fpcc_iter_stage (
    input  logic [4:0]           step,
    input  fpcc_pkg::fpcc_iter_t cur,
    output fpcc_pkg::fpcc_iter_t nxt
);

    logic signed [fpcc_pkg::XY_W-1:0] xs;
    logic signed [fpcc_pkg::XY_W-1:0] ys;
    logic signed [fpcc_pkg::XY_W-1:0] y_neg;
    logic [fpcc_pkg::REM_W-1:0]       rem_sh;
    logic [fpcc_pkg::REM_W-1:0]       dvs;
    logic                             q_bit;

    always_comb
    begin
        nxt = cur;

        // The y shift truncates toward zero, so it works on the magnitude.
        y_neg = -cur.y;
        xs    = cur.x >>> step;
        ys    = cur.y[fpcc_pkg::XY_W-1] ? -(y_neg >>> step) : (cur.y >>> step);
        if (step < fpcc_pkg::CORDIC_STEPS)
        begin
            if (!cur.y[fpcc_pkg::XY_W-1])
            begin
                nxt.x = cur.x + ys;
                nxt.y = cur.y - xs;
                nxt.z = cur.z + fpcc_pkg::atan_lut(step);
            end
            else
            begin
                nxt.x = cur.x - ys;
                nxt.y = cur.y + xs;
                nxt.z = cur.z - fpcc_pkg::atan_lut(step);
            end
        end

        // The first step gives the integer bit, the rest the fraction.
        dvs    = {1'b0, cur.sum};
        rem_sh = (step == 5'd0) ? cur.rem : {cur.rem[fpcc_pkg::REM_W-2:0], 1'b0};
        q_bit  = (rem_sh >= dvs);
        nxt.rem = q_bit ? (rem_sh - dvs) : rem_sh;
        nxt.quo = {cur.quo[fpcc_pkg::QUO_W-2:0], q_bit};
    end

endmodule

// ===== hdl/fire_pixel_color_classifier_top.sv =====
// A beat passes the front, iteration, rounding and output registers on its way out.
// Throughput: one pixel per cycle unless stalled; 17 iteration stages set the depth.
// A stall on the output halts every stage together, so nothing is lost or repeated.
// Reset clears all valid bits and the configuration registers take their reset values.
// No clearing pass is needed after reset.
module fire_pixel_color_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue [7:0], green [15:8], red [23:16]
    input  logic        s_tuser,   // motion [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // hue_x16 [13:0], saturation_q16 [29:14], sum [39:30]
    output logic [1:0]  m_tuser,   // rgb_fire [0], fire [1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fpcc_pkg::fpcc_cfg_t  cfg_reg;
    fpcc_pkg::fpcc_iter_t front_init;
    fpcc_pkg::fpcc_iter_t pipe_reg [0:17];
    fpcc_pkg::fpcc_iter_t pipe_next [1:17];

    logic        adv;
    logic        rnd_valid_reg;
    logic        rnd_ok_reg;
    logic [9:0]  rnd_sum_reg;
    logic [11:0] rnd_hue_reg;
    logic [15:0] rnd_sat_reg;
    logic [23:0] rnd_thr_reg;
    logic [11:0] hue_next;
    logic [15:0] sat_next;
    logic [20:0] z_rnd;
    logic [12:0] hue_raw;
    logic        fire_next;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic [1:0]  out_user_reg;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motion_gate_enable <= 1'b1;
            cfg_reg.red_threshold      <= 8'd230;
            cfg_reg.hue_max_degrees    <= 9'd60;
            cfg_reg.intensity_sum_min  <= 10'd450;
            cfg_reg.saturation_slope   <= 16'd199;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                fpcc_pkg::REG_MOTION_GATE: cfg_reg.motion_gate_enable <= pwdata[0];
                fpcc_pkg::REG_RED_THR:     cfg_reg.red_threshold      <= pwdata[7:0];
                fpcc_pkg::REG_HUE_MAX:     cfg_reg.hue_max_degrees    <= pwdata[8:0];
                fpcc_pkg::REG_SUM_MIN:     cfg_reg.intensity_sum_min  <= pwdata[9:0];
                fpcc_pkg::REG_SAT_SLOPE:   cfg_reg.saturation_slope   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            fpcc_pkg::REG_MOTION_GATE: prdata = {31'd0, cfg_reg.motion_gate_enable};
            fpcc_pkg::REG_RED_THR:     prdata = {24'd0, cfg_reg.red_threshold};
            fpcc_pkg::REG_HUE_MAX:     prdata = {23'd0, cfg_reg.hue_max_degrees};
            fpcc_pkg::REG_SUM_MIN:     prdata = {22'd0, cfg_reg.intensity_sum_min};
            fpcc_pkg::REG_SAT_SLOPE:   prdata = {16'd0, cfg_reg.saturation_slope};
            default:                   prdata = 32'd0;
        endcase
    end

    // The whole pipeline moves when the output register is free.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    fpcc_front u_front (
        .blue   (s_tdata[7:0]),
        .green  (s_tdata[15:8]),
        .red    (s_tdata[23:16]),
        .motion (s_tuser),
        .valid  (s_tvalid),
        .cfg    (cfg_reg),
        .init   (front_init)
    );

    // Front register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_reg[0].valid <= 1'b0;
        end
        else if (adv)
        begin
            pipe_reg[0] <= front_init;
        end
    end

    // Iteration stages.
    for (genvar k = 0; k < 17; k++)
    begin : g_iter
        fpcc_iter_stage u_stage (
            .step (5'(k)),
            .cur  (pipe_reg[k]),
            .nxt  (pipe_next[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pipe_reg[k+1].valid <= 1'b0;
            end
            else if (adv)
            begin
                pipe_reg[k+1] <= pipe_next[k+1];
            end
        end
    end

    // Round the angle to 1/16 degree and limit the quotient.
    always_comb
    begin
        z_rnd   = pipe_reg[17].z + 21'sd128;
        hue_raw = z_rnd[20:8];
        if (pipe_reg[17].z[20])
            hue_next = 12'd0;
        else if (hue_raw > fpcc_pkg::HUE_HALF_TURN)
            hue_next = fpcc_pkg::HUE_HALF_TURN[11:0];
        else
            hue_next = hue_raw[11:0];
        sat_next = pipe_reg[17].quo[16] ? 16'hFFFF : pipe_reg[17].quo[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rnd_valid_reg <= pipe_reg[17].valid;
            rnd_ok_reg    <= pipe_reg[17].rgb_ok;
            rnd_sum_reg   <= pipe_reg[17].sum;
            rnd_hue_reg   <= hue_next;
            rnd_sat_reg   <= sat_next;
            rnd_thr_reg   <= pipe_reg[17].sat_thr;
        end
    end

    // Fire decision and output register.
    assign fire_next = rnd_ok_reg
                       && ({1'b0, rnd_hue_reg} <= {cfg_reg.hue_max_degrees, 4'b0000})
                       && (rnd_sum_reg >= cfg_reg.intensity_sum_min)
                       && ({8'd0, rnd_sat_reg} >= rnd_thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= rnd_valid_reg;
            out_user_reg  <= {fire_next, rnd_ok_reg};
            out_data_reg  <= rnd_ok_reg ? {rnd_sum_reg, rnd_sat_reg, 2'b00, rnd_hue_reg}
                                        : 40'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_fire_needs_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("fire flagged without the colour rule");
    a_zero_when_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0)
        else $error("fields not cleared for a rejected pixel");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[13:0] <= 14'd2880)
        else $error("hue beyond half turn");
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped under stall");
`endif

endmodule
